// ===== sv/tsr_pkg.sv =====
// Package for the trailed store with rollback.
// Holds sizes, field types, the command, status and state codes, and word helpers.
// No dependencies.
`default_nettype none

package tsr_pkg;

    localparam int TRAIL_DEPTH = 1024;
    localparam int STORE_WORDS = 1024;
    localparam int WORD_BITS   = 32;

    localparam int ADDR_BITS   = 10;
    localparam int VALUE_BITS  = 32;
    localparam int LEVEL_BITS  = 11;
    localparam int STORE_AW    = $clog2(STORE_WORDS);
    localparam int TRAIL_AW    = $clog2(TRAIL_DEPTH);
    localparam int TRAIL_PW    = $clog2(TRAIL_DEPTH + 1);

    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

    typedef logic [WORD_BITS-1:0]         t_word;
    typedef logic [ADDR_BITS-1:0]         t_addr;
    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic [LEVEL_BITS-1:0]        t_level;
    typedef logic [TRAIL_PW-1:0]          t_tptr;
    typedef logic [STORE_AW-1:0]          t_sidx;
    typedef logic [TRAIL_AW-1:0]          t_tidx;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_UP    = 2'd2,
        CMD_DOWN  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOLEVEL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_POP,
        S_POP_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic  mark;
        t_addr addr;
        t_word word;
    } t_trail;

    function automatic logic addr_in_store(t_addr a);
        return 32'(a) < STORE_WORDS;
    endfunction

    function automatic t_word field_to_word(t_value v);
        logic [VALUE_BITS-1:0] u;
        u = $unsigned(v);
        return t_word'(u);
    endfunction

    function automatic t_value word_to_field(t_word w);
        logic signed [WORD_BITS-1:0] s;
        s = $signed(w);
        return VALUE_BITS'(s);
    endfunction

endpackage

`default_nettype wire

// ===== sv/tsr_if.sv =====
// Channel interfaces for the trailed store: the command channel and the result channel.
// Depends on tsr_pkg for the field types.
`default_nettype none

interface tsr_in_if
    import tsr_pkg::*;
();
    logic   valid;
    logic   ready;
    t_cmd   command;
    t_addr  address;
    t_value value;

    modport source (output valid, output command, output address, output value, input ready);
    modport sink   (input valid, input command, input address, input value, output ready);
endinterface

interface tsr_out_if
    import tsr_pkg::*;
();
    logic    valid;
    logic    ready;
    t_value  read_value;
    t_level  current_level;
    t_status status;

    modport source (output valid, output read_value, output current_level, output status,
                    input ready);
    modport sink   (input valid, input read_value, input current_level, input status,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/tsr_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module tsr_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/trailed_store_with_rollback.sv =====
// Top level of the trailed store with rollback: sequencer, store RAM and trail RAM.
// Depends on tsr_pkg, tsr_if and tsr_ram.
//
// A word store with an undo trail. After reset the block clears the whole store and
// holds ready low meanwhile. It takes one command at a time: a write, read or level
// up passes through the execute and done states into the result register, and the
// done state waits while that register is held by a stalled output. A level down
// pops trail entries down to and including the marker, each through a pop state and a
// pop-wait state, because each pop waits for the registered read of the single trail
// RAM. The result register lets the next command be accepted while a result still waits.
`default_nettype none

module trailed_store_with_rollback
    import tsr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tsr_in_if.sink     i_in,
    tsr_out_if.source  o_out
);

    t_state  r_state, n_state;
    t_cmd    r_cmd, n_cmd;
    t_addr   r_addr, n_addr;
    t_value  r_val, n_val;
    t_tptr   r_tp, n_tp;
    t_level  r_level, n_level;
    t_sidx   r_clr, n_clr;
    t_value  r_res_rd, n_res_rd;
    t_status r_res_status, n_res_status;
    logic    r_o_valid, n_o_valid;
    t_value  r_o_rd, n_o_rd;
    t_level  r_o_level, n_o_level;
    t_status r_o_status, n_o_status;

    logic   st_we, st_re;
    t_sidx  st_waddr, st_raddr;
    t_word  st_wdata, st_rdata;
    logic   tr_we, tr_re;
    t_tidx  tr_waddr, tr_raddr;
    t_trail tr_wdata, tr_rdata;

    logic   w_full;
    t_tptr  w_tp_dec;
    logic   w_out_free;

    assign w_full     = (r_tp == t_tptr'(TRAIL_DEPTH));
    assign w_tp_dec   = r_tp - t_tptr'(1);
    assign w_out_free = !r_o_valid || o_out.ready;

    tsr_ram #(.DEPTH(STORE_WORDS), .WIDTH(WORD_BITS)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    tsr_ram #(.DEPTH(TRAIL_DEPTH), .WIDTH($bits(t_trail))) u_trail (
        .i_clk   (i_clk),
        .i_we    (tr_we),
        .i_waddr (tr_waddr),
        .i_wdata (tr_wdata),
        .i_re    (tr_re),
        .i_raddr (tr_raddr),
        .o_rdata (tr_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == t_sidx'(STORE_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_cmd == CMD_DOWN && r_level != '0) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_POP: begin
                if (r_tp == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                if (tr_rdata.mark) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_POP;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cmd        = r_cmd;
        n_addr       = r_addr;
        n_val        = r_val;
        n_tp         = r_tp;
        n_level      = r_level;
        n_clr        = r_clr;
        n_res_rd     = r_res_rd;
        n_res_status = r_res_status;
        n_o_rd       = r_o_rd;
        n_o_level    = r_o_level;
        n_o_status   = r_o_status;
        n_o_valid    = r_o_valid && !o_out.ready;
        i_in.ready   = 1'b0;
        st_we        = 1'b0;
        st_waddr     = t_sidx'(r_addr);
        st_wdata     = field_to_word(r_val);
        st_re        = 1'b0;
        st_raddr     = t_sidx'(i_in.address);
        tr_we        = 1'b0;
        tr_waddr     = r_tp[TRAIL_AW-1:0];
        tr_wdata     = '{mark: 1'b0, addr: r_addr, word: st_rdata};
        tr_re        = 1'b0;
        tr_raddr     = w_tp_dec[TRAIL_AW-1:0];
        case (r_state)
            S_CLEAR: begin
                st_we    = 1'b1;
                st_waddr = r_clr;
                st_wdata = '0;
                n_clr    = r_clr + t_sidx'(1);
            end
            S_IDLE: begin
                i_in.ready   = 1'b1;
                st_re        = i_in.valid;
                n_cmd        = i_in.command;
                n_addr       = i_in.address;
                n_val        = i_in.value;
                n_res_rd     = '0;
                n_res_status = ST_OK;
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_WRITE: begin
                        if (w_full) begin
                            n_res_status = ST_FULL;
                        end else if (addr_in_store(r_addr)) begin
                            tr_we = 1'b1;
                            st_we = 1'b1;
                            n_tp  = r_tp + t_tptr'(1);
                        end
                    end
                    CMD_READ: begin
                        if (addr_in_store(r_addr)) begin
                            n_res_rd = word_to_field(st_rdata);
                        end
                    end
                    CMD_UP: begin
                        if (w_full || r_level == LEVEL_MAX) begin
                            n_res_status = ST_FULL;
                        end else begin
                            tr_we    = 1'b1;
                            tr_wdata = '{mark: 1'b1, addr: '0, word: '0};
                            n_tp     = r_tp + t_tptr'(1);
                            n_level  = r_level + t_level'(1);
                        end
                    end
                    CMD_DOWN: begin
                        if (r_level == '0) begin
                            n_res_status = ST_NOLEVEL;
                        end
                    end
                    default: n_res_status = ST_OK;
                endcase
            end
            S_POP: begin
                if (r_tp == '0) begin
                    n_level = r_level - t_level'(1);
                end else begin
                    tr_re = 1'b1;
                    n_tp  = w_tp_dec;
                end
            end
            S_POP_WAIT: begin
                st_waddr = t_sidx'(tr_rdata.addr);
                st_wdata = tr_rdata.word;
                if (tr_rdata.mark) begin
                    n_level = r_level - t_level'(1);
                end else if (addr_in_store(tr_rdata.addr)) begin
                    st_we = 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_rd     = r_res_rd;
                    n_o_level  = r_level;
                    n_o_status = r_res_status;
                end
            end
            default: n_o_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_tp      <= '0;
            r_level   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_tp      <= n_tp;
            r_level   <= n_level;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_addr       <= n_addr;
        r_val        <= n_val;
        r_res_rd     <= n_res_rd;
        r_res_status <= n_res_status;
        r_o_rd       <= n_o_rd;
        r_o_level    <= n_o_level;
        r_o_status   <= n_o_status;
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.read_value    = r_o_rd;
    assign o_out.current_level = r_o_level;
    assign o_out.status        = r_o_status;

endmodule

`default_nettype wire

// ===== sv/tsr_checker.sv =====
// Port-level checker for the trailed store with rollback, bound to the top level.
// Depends on tsr_pkg for the status codes.
`default_nettype none

module tsr_checker
    import tsr_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    i_in_valid,
    input wire logic    i_in_ready,
    input wire logic    i_out_valid,
    input wire logic    i_out_ready,
    input wire t_value  i_out_read_value,
    input wire t_level  i_out_current_level,
    input wire t_status i_out_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_read_value))
        else $error("Result dropped or changed while stalled.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("Second command accepted while one is in progress.");

    a_nolevel_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == ST_NOLEVEL |-> i_out_current_level == '0)
        else $error("No-level status reported with levels open.");

    a_fail_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != ST_OK |-> i_out_read_value == '0)
        else $error("Rejected command returned a non-zero word.");

endmodule

bind trailed_store_with_rollback tsr_checker u_tsr_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in.valid),
    .i_in_ready          (i_in.ready),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_out_read_value    (o_out.read_value),
    .i_out_current_level (o_out.current_level),
    .i_out_status        (o_out.status)
);

`default_nettype wire
